FILE: design/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// shared widths, limits and register indexes of the palette pattern colourizer
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  localparam int MAX_COLOURS      = 8;
  localparam int MAX_FRAME_POINTS = 4096;

  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int PAIR_W   = 2 * COLOUR_W;
  localparam int NC_W     = 4;
  localparam int IDX_W    = 3;
  localparam int LIT_W    = 13;
  localparam int POS_W    = 24;
  localparam int DIV_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLOURS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_LINEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEATS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR0        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR1        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR2        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR3        = 3'd7;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [LIT_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: design/ppc_divider.sv
// ----------------------------------------------------------------------------
// ppc_divider
// restoring divider, one quotient bit per cycle, for the per-point step
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_divider
  import ppc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire div_req_t         req,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                 busy;
  logic [4:0]           count;
  logic [LIT_W-1:0]     divisor;
  logic [LIT_W-1:0]     rem;
  logic [DIV_W-1:0]     dq;
  logic [LIT_W:0]       trial;
  logic                 ge;
  logic [LIT_W:0]       diff;

  assign trial = {rem, dq[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 5'd31;
        divisor <= req.divisor;
        rem <= '0;
        dq <= req.dividend;
      end else if (busy) begin
        rem <= ge ? diff[LIT_W-1:0] : trial[LIT_W-1:0];
        dq <= {dq[DIV_W-2:0], ge};
        count <= count - 5'd1;
        if (count == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

`default_nettype wire

FILE: design/ppc_blend_unit.sv
// ----------------------------------------------------------------------------
// ppc_blend_unit
// shared channel blender: a*(256-f)+b*f over 256, one channel per use
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_blend_unit
  import ppc_pkg::*;
(
  input  wire chan_t a,
  input  wire chan_t b,
  input  wire chan_t f,
  output chan_t      c
);

  logic signed [CHAN_W:0]       d;
  logic signed [2*CHAN_W+1:0]   prod;

  // a + floor((b - a) * f / 256) equals the two-product form exactly
  assign d    = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod = (2*CHAN_W+2)'(d) * $signed((2*CHAN_W+2)'({1'b0, f}));
  assign c    = a + prod[2*CHAN_W-1:CHAN_W];

endmodule

`default_nettype wire

FILE: design/palette_pattern_colourizer_unit.sv
// ----------------------------------------------------------------------------
// palette_pattern_colourizer_unit
// recolors lit points of a vector frame from a cyclic palette of rgb entries
//
// input channel (in_valid/in_stall) takes one word per cycle at most: a frame
// start (req_type 0) with its lit count, or a frame point (req_type 1). config
// writes (cfg_we/cfg_index/cfg_data) are registered; the user must make them
// only while idle, as the block does not enforce it. steps per accepted word:
//   frame start, nonzero count: the radix-2 divider, then idle
//   frame start, zero count: step cleared, frame inactive, stays idle
//   point passed unchanged: done
//   lit point, nearest entry: scale, fetch a, done
//   lit point, linear blend: scale, fetch a, fetch b, blend (three channels
//   through one shared multiplier), done
// a point's word reaches out_valid as the block goes idle. the output register
// holds its word while out_stall is high; the next point then waits in the
// block with in_stall high until the word is taken. frame starts give no word.
// reset clears the registers to their defaults (one repeat, no colours) and
// leaves the block idle with no frame active.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pattern_colourizer_unit
  import ppc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [PAIR_W-1:0]     cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [LIT_W-1:0]      lit_count,
  input  wire logic                  point_lit,
  input  wire logic [31:0]           point_payload,
  input  wire logic [COLOUR_W-1:0]   point_colour,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_payload,
  output logic [COLOUR_W-1:0]        out_colour,
  output logic                       out_lit
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV     = 3'd1;
  localparam logic [2:0] ST_SCALE   = 3'd2;
  localparam logic [2:0] ST_FETCH_A = 3'd3;
  localparam logic [2:0] ST_FETCH_B = 3'd4;
  localparam logic [2:0] ST_BLEND   = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [NC_W-1:0]      num_colours;
  logic                 blend_linear;
  logic [15:0]          phase;
  logic [15:0]          repeats;
  logic [PAIR_W-1:0]    pair [4];

  logic [2:0]           state;
  logic [POS_W-1:0]     position_acc;
  logic [POS_W-1:0]     position_step;
  logic                 frame_active;
  logic [IDX_W-1:0]     idx;
  chan_t                frac;
  logic [1:0]           ch;
  logic [COLOUR_W-1:0]  colour_a;
  logic [COLOUR_W-1:0]  colour_b;
  logic [31:0]          payload_q;
  logic [COLOUR_W-1:0]  colour_q;
  logic                 lit_q;

  logic                 accept;
  logic [NC_W-1:0]      nc_sat;
  logic [LIT_W-1:0]     lit_sat;
  logic [POS_W+NC_W-1:0] scale;
  logic [IDX_W-1:0]     rd_addr;
  logic [COLOUR_W-1:0]  rd_data;
  logic [PAIR_W-1:0]    rd_pair;
  logic [NC_W-1:0]      idx_inc;
  logic [IDX_W-1:0]     nxt;
  div_req_t             div_req;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;
  chan_t                blend_c;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  assign nc_sat  = (num_colours > NC_W'(MAX_COLOURS)) ? NC_W'(MAX_COLOURS) : num_colours;
  assign lit_sat = (lit_count > LIT_W'(MAX_FRAME_POINTS)) ? LIT_W'(MAX_FRAME_POINTS)
                                                          : lit_count;
  assign scale   = (POS_W+NC_W)'(position_acc) * (POS_W+NC_W)'(nc_sat);

  assign idx_inc = NC_W'(idx) + NC_W'(1);
  assign nxt     = (idx_inc >= nc_sat) ? '0 : idx_inc[IDX_W-1:0];

  // single palette read port, address chosen by sequencer step
  assign rd_addr = (state == ST_FETCH_B) ? nxt : idx;
  assign rd_pair = pair[rd_addr[IDX_W-1:1]];
  assign rd_data = rd_addr[0] ? rd_pair[PAIR_W-1:COLOUR_W] : rd_pair[COLOUR_W-1:0];

  assign div_req.start    = accept && !req_type && (lit_sat != '0);
  assign div_req.dividend = {repeats, 16'd0};
  assign div_req.divisor  = lit_sat;

  ppc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  ppc_blend_unit u_blend (
    .a (colour_a[ch*CHAN_W +: CHAN_W]),
    .b (colour_b[ch*CHAN_W +: CHAN_W]),
    .f (frac),
    .c (blend_c)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_colours <= '0;
      blend_linear <= 1'b0;
      phase <= '0;
      repeats <= 16'd256;
      for (int i = 0; i < 4; i++) begin
        pair[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLOURS:  num_colours <= cfg_data[NC_W-1:0];
        REG_BLEND_LINEAR: blend_linear <= cfg_data[0];
        REG_PHASE:        phase <= cfg_data[15:0];
        REG_REPEATS:      repeats <= cfg_data[15:0];
        REG_PAIR0:        pair[0] <= cfg_data;
        REG_PAIR1:        pair[1] <= cfg_data;
        REG_PAIR2:        pair[2] <= cfg_data;
        REG_PAIR3:        pair[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      position_acc <= '0;
      position_step <= '0;
      frame_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!req_type) begin
              position_acc <= {phase, 8'd0};
              if (lit_sat != '0) begin
                frame_active <= 1'b1;
                state <= ST_DIV;
              end else begin
                frame_active <= 1'b0;
                position_step <= '0;
              end
            end else begin
              payload_q <= point_payload;
              colour_q <= point_colour;
              lit_q <= point_lit;
              if (point_lit && (nc_sat != '0) && frame_active) begin
                state <= ST_SCALE;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            position_step <= div_q[POS_W-1:0];
            state <= ST_IDLE;
          end
        end
        ST_SCALE: begin
          idx <= scale[POS_W+IDX_W-1:POS_W];
          frac <= scale[POS_W-1:POS_W-CHAN_W];
          position_acc <= position_acc + position_step;
          state <= ST_FETCH_A;
        end
        ST_FETCH_A: begin
          colour_a <= rd_data;
          if (blend_linear) begin
            state <= ST_FETCH_B;
          end else begin
            colour_q <= rd_data;
            state <= ST_DONE;
          end
        end
        ST_FETCH_B: begin
          colour_b <= rd_data;
          ch <= 2'd0;
          state <= ST_BLEND;
        end
        ST_BLEND: begin
          colour_q[ch*CHAN_W +: CHAN_W] <= blend_c;
          ch <= ch + 2'd1;
          if (ch == 2'd2) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_payload <= payload_q;
            out_colour <= colour_q;
            out_lit <= lit_q;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
